// ===== rtl/core/earsel_pkg.sv =====
// Shared types and constants of the energy and angle relay selector.
// Holds the request/response structs, codes, micro-step numbers and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package earsel_pkg;

    // Request as it arrives on the input channel
    typedef struct packed {
        logic               req_type;
        logic [15:0]        src_addr;
        logic               bs_flag;
        logic [15:0]        cand_energy;
        logic signed [15:0] cand_pos_x;
        logic signed [15:0] cand_pos_y;
        logic [16:0]        cand_dist_to_bs;
    } t_req;

    // Result as it leaves on the output channel
    typedef struct packed {
        logic [1:0]  recorded;
        logic        dest_valid;
        logic [15:0] dest_addr;
        logic        dest_is_bs;
    } t_rsp;

    // Request type codes
    localparam logic REQ_REPORT  = 1'b0;
    localparam logic REQ_RESOLVE = 1'b1;

    // Recorded codes
    localparam logic [1:0] REC_NONE  = 2'd0;
    localparam logic [1:0] REC_BS    = 2'd1;
    localparam logic [1:0] REC_RELAY = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_DBS = 2'd2;

    // Micro-step numbers of the scoring sequence
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] STEP_SQ_X       = 6'd0;
    localparam logic [STEP_W-1:0] STEP_SQ_Y       = 6'd1;
    localparam logic [STEP_W-1:0] STEP_ROOT_INIT  = 6'd2;
    localparam logic [STEP_W-1:0] STEP_ROOT_FIRST = 6'd3;
    localparam logic [STEP_W-1:0] STEP_ROOT_LAST  = 6'd20;
    localparam logic [STEP_W-1:0] STEP_DRC        = 6'd21;
    localparam logic [STEP_W-1:0] STEP_C_DS       = 6'd22;
    localparam logic [STEP_W-1:0] STEP_C_DB       = 6'd23;
    localparam logic [STEP_W-1:0] STEP_C_DC       = 6'd24;
    localparam logic [STEP_W-1:0] STEP_C_DEN      = 6'd25;
    localparam logic [STEP_W-1:0] STEP_C_NUM      = 6'd26;
    localparam logic [STEP_W-1:0] STEP_R_DS       = 6'd27;
    localparam logic [STEP_W-1:0] STEP_R_DB       = 6'd28;
    localparam logic [STEP_W-1:0] STEP_R_DC       = 6'd29;
    localparam logic [STEP_W-1:0] STEP_R_DEN      = 6'd30;
    localparam logic [STEP_W-1:0] STEP_R_NUM      = 6'd31;
    localparam logic [STEP_W-1:0] STEP_L_LL       = 6'd32;
    localparam logic [STEP_W-1:0] STEP_L_LH       = 6'd33;
    localparam logic [STEP_W-1:0] STEP_L_HL       = 6'd34;
    localparam logic [STEP_W-1:0] STEP_L_HH       = 6'd35;
    localparam logic [STEP_W-1:0] STEP_R_LL       = 6'd36;
    localparam logic [STEP_W-1:0] STEP_R_LH       = 6'd37;
    localparam logic [STEP_W-1:0] STEP_R_HL       = 6'd38;
    localparam logic [STEP_W-1:0] STEP_R_HH       = 6'd39;
    localparam logic [STEP_W-1:0] STEP_ACC_END    = 6'd40;
    localparam logic [STEP_W-1:0] STEP_COMMIT     = 6'd41;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic              load;
        logic              run;
        logic [STEP_W-1:0] step;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic fast;
        logic relay_known;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/energy_angle_relay_selector_unit.sv =====
// Energy and angle relay selector: top level joining sequencer and datapath.
// Depends on earsel_pkg, earsel_ctrl and earsel_dpath.
//
// Usage: a request on i_req is taken when i_valid is high and o_stall low.
// A resolve request, a base-station report, or any report while a base
// station is known gives its result in the cycle after acceptance. A relay
// candidate report runs the shared 36x18 multiplier and a two-bits-a-cycle
// square root: the squares, the 18 root steps and the distance step; then,
// when scored against the stored relay, the 20 steps of the two scores, the
// cross products and the commit, else just the commit. One request is
// worked on at a time; o_stall is high from acceptance until the result
// has been taken. The result sits in an output register with o_valid high
// and holds while i_stall is high. Configuration writes on i_cfg_we are taken
// at once; the user must make them while no request is in flight (not enforced).
// Reset (synchronous, active low) clears the stored base station and relay,
// sets own position to zero and own base-station distance to one.
`default_nettype none

module energy_angle_relay_selector_unit
    import earsel_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    input  wire t_req                  i_req,
    output logic                       o_stall,
    output logic                       o_valid,
    output t_rsp                       o_rsp,
    input  wire logic                  i_stall
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    earsel_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath
    earsel_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_rsp      (o_rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/core/earsel_ctrl.sv =====
// Sequencer of the relay selector: handshakes and micro-step counter.
// Depends on earsel_pkg; drives the datapath through t_cmd.
`default_nettype none

module earsel_ctrl
    import earsel_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    // State and step registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Advance through the micro-steps, hold the result until taken
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd.load = 1'b0;
        o_cmd.run  = 1'b0;
        o_cmd.step = r_step;
        o_stall    = 1'b1;
        o_valid    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = STEP_SQ_X;
                    n_state    = i_sts.fast ? ST_OUT : ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.run = 1'b1;
                if (r_step == STEP_COMMIT) begin
                    n_state = ST_OUT;
                end else if (r_step == STEP_DRC && !i_sts.relay_known) begin
                    n_step = STEP_COMMIT;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/earsel_dpath.sv =====
// Datapath of the relay selector: configuration, stored relay state,
// shared multiplier, bit-pair square root and score comparison.
// Depends on earsel_pkg; steered by t_cmd from earsel_ctrl.
`default_nettype none

module earsel_dpath
    import earsel_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_req                  i_req,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    output t_rsp                       o_rsp
);

    // Configuration and stored state
    logic signed [15:0] r_own_x, r_own_y;
    logic [16:0]        r_own_dbs;
    logic [15:0]        r_bs_addr, r_rly_addr, r_rly_energy;
    logic [16:0]        r_rly_dbs, r_rly_dself;

    // Working registers
    t_req        r_req;
    logic [15:0] r_ux, r_uy;
    logic [53:0] r_prod;
    logic [33:0] r_sq;
    logic [34:0] r_res, r_bit;
    logic [16:0] r_drc;
    logic [36:0] r_t;
    logic [50:0] r_num2, r_num1;
    logic [33:0] r_den2, r_den1;
    logic        r_neg2, r_neg1;
    logic [85:0] r_lhs, r_rhs;
    t_rsp        r_rsp, n_rsp;

    logic signed [16:0] dx, dy;
    logic [16:0]        adx, ady;
    logic [16:0]        cand_dc, own_db, rly_ds, rly_dc;
    logic [36:0]        t_neg;
    logic [35:0]        t_mag;
    logic [35:0]        mul_a;
    logic [17:0]        mul_b;
    logic [53:0]        prod_c;
    logic [35:0]        root_sum;
    logic               take;
    logic               run;

    // Distances with zero taken as one
    assign cand_dc = (r_req.cand_dist_to_bs == '0) ? 17'd1 : r_req.cand_dist_to_bs;
    assign own_db  = (r_own_dbs == '0) ? 17'd1 : r_own_dbs;
    assign rly_ds  = (r_rly_dself == '0) ? 17'd1 : r_rly_dself;
    assign rly_dc  = (r_rly_dbs == '0) ? 17'd1 : r_rly_dbs;

    // Offsets to the candidate
    assign dx  = 17'(signed'({i_req.cand_pos_x[15], i_req.cand_pos_x}))
               - 17'(signed'({r_own_x[15], r_own_x}));
    assign dy  = 17'(signed'({i_req.cand_pos_y[15], i_req.cand_pos_y}))
               - 17'(signed'({r_own_y[15], r_own_y}));
    assign adx = dx[16] ? 17'(-dx) : 17'(dx);
    assign ady = dy[16] ? 17'(-dy) : 17'(dy);

    assign t_neg = 37'(~r_t + 37'd1);
    assign t_mag = r_t[36] ? t_neg[35:0] : r_t[35:0];

    assign run      = i_cmd.run;
    assign root_sum = {1'b0, r_res} + {1'b0, r_bit};

    // Status towards the sequencer
    assign o_sts.fast = (i_req.req_type == REQ_RESOLVE) || i_req.bs_flag
                      || (r_bs_addr != '0);
    assign o_sts.relay_known = (r_rly_addr != '0);

    // Pick multiplier operands for this step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.step)
            STEP_SQ_X: begin
                mul_a = 36'(r_ux);
                mul_b = 18'(r_ux);
            end
            STEP_SQ_Y: begin
                mul_a = 36'(r_uy);
                mul_b = 18'(r_uy);
            end
            STEP_C_DS: begin
                mul_a = 36'(r_drc);
                mul_b = 18'(r_drc);
            end
            STEP_C_DB, STEP_R_DB: begin
                mul_a = 36'(own_db);
                mul_b = 18'(own_db);
            end
            STEP_C_DC: begin
                mul_a = 36'(cand_dc);
                mul_b = 18'(cand_dc);
            end
            STEP_C_DEN: begin
                mul_a = 36'(cand_dc);
                mul_b = 18'(r_drc);
            end
            STEP_C_NUM: begin
                mul_a = t_mag;
                mul_b = 18'(r_req.cand_energy);
            end
            STEP_R_DS: begin
                mul_a = 36'(rly_ds);
                mul_b = 18'(rly_ds);
            end
            STEP_R_DC: begin
                mul_a = 36'(rly_dc);
                mul_b = 18'(rly_dc);
            end
            STEP_R_DEN: begin
                mul_a = 36'(rly_dc);
                mul_b = 18'(rly_ds);
            end
            STEP_R_NUM: begin
                mul_a = t_mag;
                mul_b = 18'(r_rly_energy);
            end
            STEP_L_LL: begin
                mul_a = 36'(r_num2[33:0]);
                mul_b = 18'(r_den1[16:0]);
            end
            STEP_L_LH: begin
                mul_a = 36'(r_num2[33:0]);
                mul_b = 18'(r_den1[33:17]);
            end
            STEP_L_HL: begin
                mul_a = 36'(r_num2[50:34]);
                mul_b = 18'(r_den1[16:0]);
            end
            STEP_L_HH: begin
                mul_a = 36'(r_num2[50:34]);
                mul_b = 18'(r_den1[33:17]);
            end
            STEP_R_LL: begin
                mul_a = 36'(r_num1[33:0]);
                mul_b = 18'(r_den2[16:0]);
            end
            STEP_R_LH: begin
                mul_a = 36'(r_num1[33:0]);
                mul_b = 18'(r_den2[33:17]);
            end
            STEP_R_HL: begin
                mul_a = 36'(r_num1[50:34]);
                mul_b = 18'(r_den2[16:0]);
            end
            STEP_R_HH: begin
                mul_a = 36'(r_num1[50:34]);
                mul_b = 18'(r_den2[33:17]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;

    // Decide replacement: the stored relay is kept on equal scores
    always_comb begin
        if (!o_sts.relay_known) begin
            take = 1'b1;
        end else if (r_neg2 != r_neg1) begin
            take = !r_neg2;
        end else if (r_neg2) begin
            take = (r_lhs < r_rhs);
        end else begin
            take = (r_lhs > r_rhs);
        end
    end

    // Configuration and stored state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_x      <= '0;
            r_own_y      <= '0;
            r_own_dbs    <= 17'd1;
            r_bs_addr    <= '0;
            r_rly_addr   <= '0;
            r_rly_energy <= '0;
            r_rly_dbs    <= '0;
            r_rly_dself  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OWN_X:   r_own_x   <= signed'(i_cfg_data[15:0]);
                    CFG_OWN_Y:   r_own_y   <= signed'(i_cfg_data[15:0]);
                    CFG_OWN_DBS: r_own_dbs <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load && i_req.req_type == REQ_REPORT && i_req.bs_flag) begin
                r_bs_addr <= i_req.src_addr;
            end
            if (run && i_cmd.step == STEP_COMMIT && take) begin
                r_rly_addr   <= r_req.src_addr;
                r_rly_energy <= r_req.cand_energy;
                r_rly_dbs    <= cand_dc;
                r_rly_dself  <= r_drc;
            end
        end
    end

    // Capture the request and work through the steps
    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;
        if (i_cmd.load) begin
            r_req <= i_req;
            r_ux  <= adx[15:0];
            r_uy  <= ady[15:0];
        end
        if (run) begin
            if (i_cmd.step == STEP_SQ_Y) begin
                r_sq <= r_prod[33:0];
            end
            if (i_cmd.step == STEP_ROOT_INIT) begin
                r_sq  <= r_sq + r_prod[33:0];
                r_res <= '0;
                r_bit <= 35'd1 << 34;
            end
            if (i_cmd.step inside {[STEP_ROOT_FIRST:STEP_ROOT_LAST]}) begin
                if ({2'b00, r_sq} >= root_sum) begin
                    r_sq  <= r_sq - root_sum[33:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            if (i_cmd.step == STEP_DRC) begin
                r_drc <= (r_res[16:0] == '0) ? 17'd1 : r_res[16:0];
            end
            // Score terms: t = ds^2 + db^2 - dc^2
            if (i_cmd.step == STEP_C_DB || i_cmd.step == STEP_R_DB) begin
                r_t <= 37'(r_prod[33:0]);
            end
            if (i_cmd.step == STEP_C_DC || i_cmd.step == STEP_R_DC) begin
                r_t <= r_t + 37'(r_prod[33:0]);
            end
            if (i_cmd.step == STEP_C_DEN || i_cmd.step == STEP_R_DEN) begin
                r_t <= r_t - 37'(r_prod[33:0]);
            end
            if (i_cmd.step == STEP_C_NUM) begin
                r_den2 <= r_prod[33:0];
            end
            if (i_cmd.step == STEP_R_DS) begin
                r_num2 <= r_prod[50:0];
                r_neg2 <= r_t[36] && (r_prod[50:0] != '0);
            end
            if (i_cmd.step == STEP_R_NUM) begin
                r_den1 <= r_prod[33:0];
            end
            if (i_cmd.step == STEP_L_LL) begin
                r_num1 <= r_prod[50:0];
                r_neg1 <= r_t[36] && (r_prod[50:0] != '0);
            end
            // Cross products from 34-bit and 17-bit slices
            if (i_cmd.step == STEP_L_LH) begin
                r_lhs <= 86'(r_prod);
            end
            if (i_cmd.step == STEP_L_HL) begin
                r_lhs <= r_lhs + (86'(r_prod) << 17);
            end
            if (i_cmd.step == STEP_L_HH) begin
                r_lhs <= r_lhs + (86'(r_prod) << 34);
            end
            if (i_cmd.step == STEP_R_LL) begin
                r_lhs <= r_lhs + (86'(r_prod) << 51);
            end
            if (i_cmd.step == STEP_R_LH) begin
                r_rhs <= 86'(r_prod);
            end
            if (i_cmd.step == STEP_R_HL) begin
                r_rhs <= r_rhs + (86'(r_prod) << 17);
            end
            if (i_cmd.step == STEP_R_HH) begin
                r_rhs <= r_rhs + (86'(r_prod) << 34);
            end
            if (i_cmd.step == STEP_ACC_END) begin
                r_rhs <= r_rhs + (86'(r_prod) << 51);
            end
        end
    end

    // Next result: set on load, replaced at commit
    always_comb begin
        n_rsp = r_rsp;
        if (i_cmd.load) begin
            n_rsp = '0;
            if (i_req.req_type == REQ_RESOLVE) begin
                if (r_bs_addr != '0) begin
                    n_rsp.dest_valid = 1'b1;
                    n_rsp.dest_addr  = r_bs_addr;
                    n_rsp.dest_is_bs = 1'b1;
                end else if (r_rly_addr != '0) begin
                    n_rsp.dest_valid = 1'b1;
                    n_rsp.dest_addr  = r_rly_addr;
                end
            end else if (i_req.bs_flag) begin
                n_rsp.recorded = REC_BS;
            end
        end else if (run && i_cmd.step == STEP_COMMIT) begin
            n_rsp = '0;
            n_rsp.recorded = take ? REC_RELAY : REC_NONE;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire
